[rtl/core/btha_pkg.sv]
// Shared types, codes and defaults for the block-table heap allocator.
// No dependencies; every other file of the block imports this package.
package btha_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_BLOCKS_DEF     = 64;
  localparam int unsigned HEADER_BYTES_DEF   = 16;
  localparam int unsigned HEAP_ADDR_BITS_DEF = 20;

  // Fixed field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned NEED_W = 22;
  localparam int unsigned CNT_OUT_W = 7;

  // Smallest payload handed out, and the allocation granule
  localparam int unsigned MIN_PAYLOAD = 16;
  localparam int unsigned ALIGN_BYTES = 8;

  // Register reset values
  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = '0;
  localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = SIZE_W'(1048576);

  typedef enum logic [2:0] {
    CMD_INIT        = 3'd0,
    CMD_ALLOC_FIRST = 3'd1,
    CMD_ALLOC_BEST  = 3'd2,
    CMD_FREE        = 3'd3,
    CMD_STATS       = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_ZERO     = 3'd1,
    STS_NO_MEM   = 3'd2,
    STS_IGNORED  = 3'd3,
    STS_DBL_FREE = 3'd4,
    STS_INIT_REJ = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_HEAP_BASE = 1'b0,
    REG_HEAP_SIZE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_SCAN,
    S_WALK,
    S_SPLIT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ALLOC,
    OP_FREE
  } op_e;

  // One table entry as held in a cell
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } entry_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic   clear;
    logic   pop;
    logic   push;
    entry_t push_entry;
  } chain_ctl_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;
    logic              free_addr_null;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_W-1:0]    alloc_addr;
    logic [SIZE_W-1:0]    used_bytes;
    logic [SIZE_W-1:0]    spare_bytes;
    logic [ADDR_W-1:0]    alloc_count;
    logic [ADDR_W-1:0]    release_count;
    logic [CNT_OUT_W-1:0] free_blocks;
    logic [SIZE_W-1:0]    max_free_size;
  } rsp_t;

endpackage

[rtl/core/btha_cell.sv]
// One cell of the block table: holds one entry and acts as a queue slot.
// Depends on btha_pkg for entry_t and chain_ctl_t.
module btha_cell import btha_pkg::*; #(
  parameter bit                IS_HEAD  = 1'b0,
  parameter logic [SIZE_W-1:0] RST_SIZE = '0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_ctl_t ctl_i,
  input  logic       left_valid_i,
  input  entry_t     right_i,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // Shift toward the head on pop; append the pushed entry at the tail
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.clear) begin
      entry_d.valid = 1'b0;
    end else if (ctl_i.pop) begin
      if (right_i.valid) begin
        entry_d = right_i;
      end else if (entry_q.valid && ctl_i.push) begin
        entry_d = ctl_i.push_entry;
        entry_d.valid = 1'b1;
      end else begin
        entry_d.valid = 1'b0;
      end
    end else if (ctl_i.push && !entry_q.valid && left_valid_i) begin
      entry_d = ctl_i.push_entry;
      entry_d.valid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.valid   <= IS_HEAD;
      entry_q.offset  <= '0;
      entry_q.size    <= IS_HEAD ? RST_SIZE : '0;
      entry_q.is_free <= IS_HEAD;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

[rtl/core/btha_chain.sv]
// Row of table cells forming a shift queue; the head cell is read out.
// Depends on btha_pkg and btha_cell.
module btha_chain import btha_pkg::*; #(
  parameter int unsigned       MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter logic [SIZE_W-1:0] RST_SIZE   = '0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chain_ctl_t ctl_i,
  output entry_t     head_o
);

  entry_t cells [MAX_BLOCKS];

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    logic   left_valid;
    entry_t right;

    if (g == 0) begin : g_first
      assign left_valid = 1'b1;
    end else begin : g_rest
      assign left_valid = cells[g-1].valid;
    end

    if (g == MAX_BLOCKS - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cells[g+1];
    end

    btha_cell #(
      .IS_HEAD  (g == 0),
      .RST_SIZE (RST_SIZE)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .left_valid_i (left_valid),
      .right_i      (right),
      .entry_o      (cells[g])
    );
  end

  assign head_o = cells[0];

endmodule

[rtl/core/block_table_heap_allocator.sv]
// Block-table heap allocator: command sequencer, statistics and cell chain.
// Depends on btha_pkg and btha_chain.
//
// Usage: commands enter on the in channel (valid/ready), one result per
// command leaves on the out channel (valid/ready). The table is a row of
// MAX_BLOCKS cells used as a rotating queue: the sequencer pops the head
// entry, rewrites it if needed and pushes it back at the tail, one entry
// per cycle except while the split step inserts a new block.
// Steps per command: allocation and free run a search pass, a rewrite
// pass (plus a split step when a block is split) and a retire step;
// requests rejected at decode, stats and rejected init run the rewrite
// pass and retire; an accepted init clears the table, seeds one free
// block, walks it and retires. One command is worked at a time: ready
// returns as the result is registered, so a new command can be taken
// while the previous result is still waiting to be taken.
// The registers heap_base/heap_size are written on the plain write port
// and only take effect at the next accepted init command.
// Reset leaves one free block covering the default heap and zero counts.
// When the receiver stalls, the finished result holds in the output
// register and a following command waits at its last step.
module block_table_heap_allocator import btha_pkg::*; #(
  parameter int unsigned MAX_BLOCKS     = MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES   = HEADER_BYTES_DEF,
  parameter int unsigned HEAP_ADDR_BITS = HEAP_ADDR_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              out_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ADDR_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam longint CAP_L = longint'(1) << HEAP_ADDR_BITS;
  localparam longint RST_SPAN_L =
    (longint'(HEAP_SIZE_RST) > CAP_L) ? CAP_L : longint'(HEAP_SIZE_RST);
  localparam logic [SIZE_W-1:0] RST_SPAN = SIZE_W'(RST_SPAN_L);
  localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'(RST_SPAN_L - longint'(HEADER_BYTES));
  localparam logic [ADDR_W-1:0] CAP32 = ADDR_W'(CAP_L);
  localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
  localparam logic [NEED_W-1:0] HDR_N = NEED_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HDR_A = ADDR_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] INIT_MIN = ADDR_W'(HEADER_BYTES + MIN_PAYLOAD);
  localparam logic [NEED_W-1:0] MIN_N = NEED_W'(MIN_PAYLOAD);
  localparam logic [NEED_W-1:0] ALIGN_M = NEED_W'(ALIGN_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Configuration registers
  logic [ADDR_W-1:0] heap_base_q;
  logic [SIZE_W-1:0] heap_size_q;

  // Table statistics and latched heap geometry
  logic [ADDR_W-1:0] lat_base_q;
  logic [SIZE_W-1:0] lat_span_q;
  logic [CNT_W-1:0]  blk_cnt_q;
  logic [ADDR_W-1:0] alloc_total_q, free_total_q;
  logic [SIZE_W-1:0] alloc_bytes_q;

  // Per-command working registers
  state_e            state_q, state_d;
  op_e               op_q;
  status_e           status_q;
  logic              best_q;
  logic [NEED_W-1:0] need_q;
  logic [ADDR_W-1:0] rel_q;
  logic [CNT_W-1:0]  j_q;
  logic              found_q;
  logic [CNT_W-1:0]  pick_q;
  logic [SIZE_W-1:0] pick_off_q, pick_size_q;
  logic              pick_free_q;
  logic              nxt_seen_q, nxt_free_q;
  logic [SIZE_W-1:0] nxt_size_q;
  logic [CNT_W-1:0]  nfree_q;
  logic [SIZE_W-1:0] largest_q;

  logic out_valid_q;
  rsp_t out_q;

  chain_ctl_t ctl;
  entry_t     head;

  btha_chain #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .RST_SIZE   (RST_SIZE)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .head_o (head)
  );

  // Command decode at the input transfer
  logic [SIZE_W-1:0] span_eff;
  logic [NEED_W-1:0] need_rnd, need_in;
  logic [ADDR_W-1:0] rel_in;
  logic              in_xfer;
  cmd_e              cmd_in;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign cmd_in   = cmd_e'(in_i.cmd);
  assign span_eff = ({{(ADDR_W-SIZE_W){1'b0}}, heap_size_q} > CAP32) ?
                    SIZE_W'(CAP32) : heap_size_q;
  assign need_rnd = (NEED_W'(in_i.req_size) + ALIGN_M) & ~ALIGN_M;
  assign need_in  = (need_rnd < MIN_N) ? MIN_N : need_rnd;
  assign rel_in   = in_i.free_addr - HDR_A - lat_base_q;

  // Derived decisions for the rewrite pass
  logic [CNT_W-1:0] last_j;
  logic             act_alloc, act_free, split, merge, hit, hit_next;

  assign last_j    = blk_cnt_q - CNT_ONE;
  assign act_alloc = (op_q == OP_ALLOC) && found_q;
  assign act_free  = (op_q == OP_FREE) && found_q && !pick_free_q;
  assign split     = ({1'b0, pick_size_q} > need_q + HDR_N + MIN_N) && (blk_cnt_q < CNT_MAX);
  assign merge     = nxt_seen_q && nxt_free_q;
  assign hit       = (j_q == pick_q);
  assign hit_next  = (j_q == pick_q + CNT_ONE);

  // Search-pass compare on the head entry
  logic fits, take_alloc, take_free;
  assign fits       = head.is_free && ({1'b0, head.size} >= need_q);
  assign take_alloc = (op_q == OP_ALLOC) && fits &&
                      (!found_q || (best_q && (head.size < pick_size_q)));
  assign take_free  = (op_q == OP_FREE) && !found_q &&
                      ({{(ADDR_W-SIZE_W){1'b0}}, head.offset} == rel_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (cmd_in)
            CMD_INIT: begin
              state_d = ({{(ADDR_W-SIZE_W){1'b0}}, span_eff} < INIT_MIN) ? S_WALK : S_CLEAR;
            end
            CMD_ALLOC_FIRST, CMD_ALLOC_BEST: begin
              state_d = (in_i.req_size == '0) ? S_WALK : S_SCAN;
            end
            CMD_FREE: begin
              state_d = (in_i.free_addr_null ||
                         (rel_in >= {{(ADDR_W-SIZE_W){1'b0}}, lat_span_q})) ? S_WALK : S_SCAN;
            end
            default: state_d = S_WALK;
          endcase
        end
      end
      S_CLEAR: state_d = S_SEED;
      S_SEED:  state_d = S_WALK;
      S_SCAN: begin
        if (j_q == last_j) state_d = S_WALK;
      end
      S_WALK: begin
        if (act_alloc && hit && split) state_d = S_SPLIT;
        else if (j_q == last_j)        state_d = S_DONE;
      end
      S_SPLIT: begin
        state_d = (j_q == blk_cnt_q) ? S_DONE : S_WALK;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Chain control
  always_comb begin
    ctl = '0;
    ctl.push_entry = head;
    case (state_q)
      S_CLEAR: ctl.clear = 1'b1;
      S_SEED: begin
        ctl.push = 1'b1;
        ctl.push_entry.valid   = 1'b1;
        ctl.push_entry.offset  = '0;
        ctl.push_entry.size    = lat_span_q - HDR;
        ctl.push_entry.is_free = 1'b1;
      end
      S_SCAN: begin
        ctl.pop  = 1'b1;
        ctl.push = 1'b1;
      end
      S_WALK: begin
        ctl.pop  = 1'b1;
        ctl.push = 1'b1;
        if (act_alloc && hit) begin
          ctl.push_entry.is_free = 1'b0;
          if (split) ctl.push_entry.size = SIZE_W'(need_q);
        end else if (act_free && hit) begin
          ctl.push_entry.is_free = 1'b1;
          if (merge) ctl.push_entry.size = head.size + HDR + nxt_size_q;
        end else if (act_free && merge && hit_next) begin
          // drop the block absorbed by the merge
          ctl.push = 1'b0;
        end
      end
      S_SPLIT: begin
        ctl.push = 1'b1;
        ctl.push_entry.valid   = 1'b1;
        ctl.push_entry.offset  = pick_off_q + HDR + SIZE_W'(need_q);
        ctl.push_entry.size    = pick_size_q - SIZE_W'(need_q) - HDR;
        ctl.push_entry.is_free = 1'b1;
      end
      default: ;
    endcase
  end

  // Final results of the command
  status_e           fin_status;
  logic [CNT_W-1:0]  fin_cnt;
  logic [SIZE_W-1:0] fin_bytes;

  always_comb begin
    fin_status = status_q;
    fin_cnt    = blk_cnt_q;
    fin_bytes  = alloc_bytes_q;
    if (status_q == STS_OK) begin
      if (op_q == OP_ALLOC && !found_q)      fin_status = STS_NO_MEM;
      else if (op_q == OP_FREE && !found_q)  fin_status = STS_IGNORED;
      else if (op_q == OP_FREE && pick_free_q) fin_status = STS_DBL_FREE;
    end
    if (act_alloc) begin
      if (split) begin
        fin_cnt   = blk_cnt_q + CNT_ONE;
        fin_bytes = alloc_bytes_q + SIZE_W'(need_q);
      end else begin
        fin_bytes = alloc_bytes_q + pick_size_q;
      end
    end else if (act_free) begin
      fin_bytes = alloc_bytes_q - pick_size_q;
      if (merge) fin_cnt = blk_cnt_q - CNT_ONE;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= HEAP_BASE_RST;
      heap_size_q <= HEAP_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HEAP_BASE: heap_base_q <= cfg_data_i;
        REG_HEAP_SIZE: heap_size_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= OP_NONE;
      status_q      <= STS_OK;
      lat_base_q    <= HEAP_BASE_RST;
      lat_span_q    <= RST_SPAN;
      blk_cnt_q     <= CNT_ONE;
      alloc_total_q <= '0;
      free_total_q  <= '0;
      alloc_bytes_q <= '0;
      out_valid_q   <= 1'b0;
      j_q           <= '0;
      found_q       <= 1'b0;
      nxt_seen_q    <= 1'b0;
      nfree_q       <= '0;
      largest_q     <= '0;
    end else begin
      state_q <= state_d;
      // Raise valid as the command retires, drop it after the output transfer
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            need_q     <= need_in;
            rel_q      <= rel_in;
            best_q     <= (cmd_in == CMD_ALLOC_BEST);
            j_q        <= '0;
            found_q    <= 1'b0;
            nxt_seen_q <= 1'b0;
            nfree_q    <= '0;
            largest_q  <= '0;
            op_q       <= OP_NONE;
            status_q   <= STS_OK;
            case (cmd_in)
              CMD_INIT: begin
                if ({{(ADDR_W-SIZE_W){1'b0}}, span_eff} < INIT_MIN) status_q <= STS_INIT_REJ;
              end
              CMD_ALLOC_FIRST, CMD_ALLOC_BEST: begin
                if (in_i.req_size == '0) status_q <= STS_ZERO;
                else                     op_q     <= OP_ALLOC;
              end
              CMD_FREE: begin
                if (in_i.free_addr_null ||
                    (rel_in >= {{(ADDR_W-SIZE_W){1'b0}}, lat_span_q})) begin
                  status_q <= STS_IGNORED;
                end else begin
                  op_q <= OP_FREE;
                end
              end
              default: ;
            endcase
          end
        end
        S_CLEAR: begin
          lat_base_q    <= heap_base_q;
          lat_span_q    <= span_eff;
          blk_cnt_q     <= CNT_ONE;
          alloc_total_q <= '0;
          free_total_q  <= '0;
          alloc_bytes_q <= '0;
        end
        S_SCAN: begin
          j_q <= (j_q == last_j) ? '0 : j_q + CNT_ONE;
          if (take_alloc || take_free) begin
            found_q     <= 1'b1;
            pick_q      <= j_q;
            pick_off_q  <= head.offset;
            pick_size_q <= head.size;
            pick_free_q <= head.is_free;
          end
          if (found_q && !nxt_seen_q) begin
            nxt_seen_q <= 1'b1;
            nxt_free_q <= head.is_free;
            nxt_size_q <= head.size;
          end
        end
        S_WALK, S_SPLIT: begin
          if (ctl.pop) j_q <= j_q + CNT_ONE;
          if (ctl.push && ctl.push_entry.is_free) begin
            nfree_q <= nfree_q + CNT_ONE;
            if (ctl.push_entry.size > largest_q) largest_q <= ctl.push_entry.size;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            blk_cnt_q     <= fin_cnt;
            alloc_bytes_q <= fin_bytes;
            if (act_alloc) alloc_total_q <= alloc_total_q + 1'b1;
            if (act_free)  free_total_q  <= free_total_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register, loaded as the command retires
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.status        <= fin_status;
      out_q.alloc_addr    <= act_alloc ?
                             (lat_base_q + {{(ADDR_W-SIZE_W){1'b0}}, pick_off_q} + HDR_A) : '0;
      out_q.used_bytes    <= fin_bytes;
      out_q.spare_bytes   <= lat_span_q - fin_bytes - SIZE_W'(fin_cnt * HDR);
      out_q.alloc_count   <= act_alloc ? alloc_total_q + 1'b1 : alloc_total_q;
      out_q.release_count <= act_free ? free_total_q + 1'b1 : free_total_q;
      out_q.free_blocks   <= CNT_OUT_W'(nfree_q);
      out_q.max_free_size <= largest_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[rtl/core/btha_checker.sv]
// Port-level checks for the block-table heap allocator, bound to the top.
// Depends on btha_pkg and block_table_heap_allocator.
module btha_checker import btha_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // Drop ready after every input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a transfer");

  // Zero address on every result whose status is not OK
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != STS_OK) |-> (out_o.alloc_addr == '0))
    else $error("address on a failed command");

  // No largest free block without free blocks
  a_largest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.free_blocks == '0) |-> (out_o.max_free_size == '0))
    else $error("largest free block without free blocks");

endmodule

bind block_table_heap_allocator btha_checker u_btha_checker (.*);
